// ===== hdl/wch_pkg.sv =====
// ----------------------------------------------------------------------------
// wch_pkg
// Shared types, sizes and codes of the word correlation histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package wch_pkg;

  localparam int MAX_WORD_CHARS = 4;
  localparam int MAX_CHAR_BITS  = 3;
  localparam int COUNT_BITS_DEF = 32;
  localparam int MIN_WORD_CHARS = 2;
  localparam int MIN_CHAR_BITS  = 1;

  localparam int KEY_BITS       = MAX_WORD_CHARS - 1;
  localparam int ADDR_BITS      = 4 * KEY_BITS;
  localparam int WORD_BITS      = MAX_WORD_CHARS * MAX_CHAR_BITS;
  localparam int LEN_BITS       = $clog2(MAX_WORD_CHARS + 1);
  localparam int CB_BITS        = $clog2(MAX_CHAR_BITS + 1);
  localparam int BETA_BITS      = 4;
  localparam int INC_BITS       = 16;
  localparam int OUT_COUNT_BITS = 32;
  localparam int WLEN_REG_BITS  = 3;
  localparam int CBITS_REG_BITS = 2;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_BITS-1:0] key_t;
  typedef logic [KEY_BITS-1:0]  corr_t;

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_READ     = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_SKIPPED  = 3'd1;
  localparam logic [2:0] ST_ENTRY    = 3'd2;
  localparam logic [2:0] ST_NO_MORE  = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  localparam logic REG_WORD_LEN  = 1'b0;
  localparam logic REG_CHAR_BITS = 1'b1;

  typedef struct packed {
    logic [1:0]           operation;
    logic [BETA_BITS-1:0] beta;
    word_t                word_a;
    word_t                word_b;
    logic [INC_BITS-1:0]  increment;
  } in_t;

  typedef struct packed {
    logic [2:0]                status;
    corr_t                     corr_ab;
    corr_t                     corr_ba;
    corr_t                     corr_aa;
    corr_t                     corr_bb;
    logic [BETA_BITS-1:0]      rep_beta;
    word_t                     rep_word_a;
    word_t                     rep_word_b;
    logic [OUT_COUNT_BITS-1:0] class_count;
    logic                      last;
  } out_t;

  typedef struct packed {
    logic [BETA_BITS-1:0] beta;
    word_t                wa;
    word_t                wb;
  } rep_t;

endpackage

`default_nettype wire

// ===== hdl/wch_key.sv =====
// ----------------------------------------------------------------------------
// wch_key
// Masks a word pair, computes the four overlap vectors and forms the
// canonical histogram key.
// ----------------------------------------------------------------------------
`default_nettype none

module wch_key (
  input  wch_pkg::word_t                 word_a,
  input  wch_pkg::word_t                 word_b,
  input  logic [wch_pkg::LEN_BITS-1:0]   len,
  input  logic [wch_pkg::CB_BITS-1:0]    cb,
  output wch_pkg::key_t                  key,
  output wch_pkg::word_t                 a_m,
  output wch_pkg::word_t                 b_m,
  output logic                           equal
);
  import wch_pkg::*;

  localparam int SW = $clog2(WORD_BITS + 1);

  function automatic word_t low_mask(logic [SW-1:0] n);
    low_mask = ~({WORD_BITS{1'b1}} << n);
  endfunction

  // suffix of x against prefix of y, shifts 1..len-1
  function automatic corr_t overlap(word_t x, word_t y, logic [LEN_BITS-1:0] l,
                                    logic [CB_BITS-1:0] c);
    corr_t               v;
    logic [SW-1:0]       sh;
    logic [SW-1:0]       n;
    logic [LEN_BITS-1:0] pos;
    v = '0;
    for (int k = 1; k < MAX_WORD_CHARS; k++) begin
      sh  = SW'(k) * SW'(c);
      n   = SW'(l - LEN_BITS'(k)) * SW'(c);
      pos = l - LEN_BITS'(1) - LEN_BITS'(k);
      if (LEN_BITS'(k) < l) begin
        if (((x ^ (y >> sh)) & low_mask(n)) == '0) begin
          v = v | (KEY_BITS'(1) << pos);
        end
      end
    end
    return v;
  endfunction

  word_t wmask;
  corr_t aa, bb, ab, ba;

  always_comb begin
    wmask = low_mask(SW'(len) * SW'(cb));
    a_m   = word_a & wmask;
    b_m   = word_b & wmask;
    equal = (a_m == b_m);
    aa    = overlap(a_m, a_m, len, cb);
    bb    = overlap(b_m, b_m, len, cb);
    ab    = overlap(a_m, b_m, len, cb);
    ba    = overlap(b_m, a_m, len, cb);
    key   = {(ab < ba) ? ba : ab, (ab < ba) ? ab : ba,
             (aa < bb) ? bb : aa, (aa < bb) ? aa : bb};
  end

endmodule

`default_nettype wire

// ===== hdl/word_correlation_histogram.sv =====
// ----------------------------------------------------------------------------
// word_correlation_histogram
// Histogram of overlap correlation classes of word pairs, held in memory.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. An insert forms the
// key and reads the entry in the transfer cycle, updates the entry in the
// next, and its result strobes in the cycle after that. A readout examines
// one table entry per cycle from the scan position up to the nonzero entry
// after the one it returns (or the table end). A clear writes one count
// per cycle over all 4096 entries at the default size, which is
// 2**(4*(MAX_WORD_CHARS-1)), and the same clearing pass runs after reset
// with busy high. Configuration writes are taken at any time. Each result
// is on out_data for exactly one cycle with out_strobe high; the receiver
// cannot hold it off.
// ----------------------------------------------------------------------------
`default_nettype none

module word_correlation_histogram #(
  parameter int COUNT_BITS = wch_pkg::COUNT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  wch_pkg::in_t   in_data,
  output wch_pkg::out_t  out_data,
  output logic           out_strobe,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import wch_pkg::*;

  localparam int DEPTH = 2 ** ADDR_BITS;
  localparam logic [ADDR_BITS:0] LAST_IDX = {1'b0, {ADDR_BITS{1'b1}}};
  localparam logic [ADDR_BITS:0] END_IDX  = {1'b1, {ADDR_BITS{1'b0}}};

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_UPD, S_SCAN1, S_SCAN2} state_t;

  function automatic out_t pack_entry(logic [2:0] st, key_t k, rep_t rp,
                                      logic [COUNT_BITS-1:0] c, logic lst);
    out_t o;
    o             = '0;
    o.status      = st;
    o.corr_ab     = k[4*KEY_BITS-1:3*KEY_BITS];
    o.corr_ba     = k[3*KEY_BITS-1:2*KEY_BITS];
    o.corr_aa     = k[2*KEY_BITS-1:KEY_BITS];
    o.corr_bb     = k[KEY_BITS-1:0];
    o.rep_beta    = rp.beta;
    o.rep_word_a  = rp.wa;
    o.rep_word_b  = rp.wb;
    o.class_count = OUT_COUNT_BITS'(c);
    o.last        = lst;
    return o;
  endfunction

  function automatic out_t pack_code(logic [2:0] st, logic lst);
    out_t o;
    o        = '0;
    o.status = st;
    o.last   = lst;
    return o;
  endfunction

  state_t                     state_r;
  logic [WLEN_REG_BITS-1:0]   word_len_r;
  logic [CBITS_REG_BITS-1:0]  char_bits_r;
  logic [ADDR_BITS:0]         idx_r;
  logic [ADDR_BITS:0]         scan_pos_r;
  logic                       clr_emit_r;
  logic                       chk_v_r;
  key_t                       chk_idx_r;
  key_t                       fnd_idx_r;
  logic [COUNT_BITS-1:0]      fnd_cnt_r;
  rep_t                       fnd_rep_r;
  key_t                       key_r;
  word_t                      a_r;
  word_t                      b_r;
  logic [BETA_BITS-1:0]       beta_r;
  logic [INC_BITS-1:0]        inc_r;
  logic                       eq_r;

  logic [COUNT_BITS-1:0]      cnt_mem [DEPTH];
  rep_t                       rep_mem [DEPTH];
  logic [COUNT_BITS-1:0]      cnt_q;
  rep_t                       rep_q;

  logic [LEN_BITS-1:0]        eff_len;
  logic [CB_BITS-1:0]         eff_cb;
  key_t                       key;
  word_t                      a_m;
  word_t                      b_m;
  logic                       equal;
  logic                       accept;
  logic                       cfg_wr;
  key_t                       rd_addr;
  logic                       cnt_we;
  key_t                       cnt_waddr;
  logic [COUNT_BITS-1:0]      cnt_wdata;
  logic                       rep_we;
  logic                       rep_upd;
  rep_t                       new_rep;
  logic [COUNT_BITS:0]        sum;
  logic [COUNT_BITS-1:0]      new_cnt;
  logic                       issuing;
  logic                       hit;
  logic                       at_end;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_WORD_LEN:  prdata = 32'(word_len_r);
      REG_CHAR_BITS: prdata = 32'(char_bits_r);
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    priority if (int'(word_len_r) < MIN_WORD_CHARS) begin
      eff_len = LEN_BITS'(MIN_WORD_CHARS);
    end else if (int'(word_len_r) > MAX_WORD_CHARS) begin
      eff_len = LEN_BITS'(MAX_WORD_CHARS);
    end else begin
      eff_len = LEN_BITS'(word_len_r);
    end
    priority if (int'(char_bits_r) < MIN_CHAR_BITS) begin
      eff_cb = CB_BITS'(MIN_CHAR_BITS);
    end else if (int'(char_bits_r) > MAX_CHAR_BITS) begin
      eff_cb = CB_BITS'(MAX_CHAR_BITS);
    end else begin
      eff_cb = CB_BITS'(char_bits_r);
    end
  end

  wch_key u_key (
    .word_a (in_data.word_a),
    .word_b (in_data.word_b),
    .len    (eff_len),
    .cb     (eff_cb),
    .key    (key),
    .a_m    (a_m),
    .b_m    (b_m),
    .equal  (equal)
  );

  assign rd_addr = (state_r == S_IDLE) ? key : idx_r[ADDR_BITS-1:0];

  assign sum     = {1'b0, cnt_q} + (COUNT_BITS+1)'(inc_r);
  assign new_cnt = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
  assign rep_upd = (cnt_q == '0) || (rep_q.beta > beta_r);
  assign new_rep = '{beta: beta_r, wa: a_r, wb: b_r};

  assign issuing = (idx_r != END_IDX);
  assign hit     = chk_v_r && (cnt_q != '0);
  assign at_end  = !chk_v_r && (idx_r == END_IDX);

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = idx_r[ADDR_BITS-1:0];
    cnt_wdata = '0;
    rep_we    = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cnt_we = 1'b1;
      end
      S_UPD: begin
        if (!eq_r) begin
          cnt_we    = 1'b1;
          cnt_waddr = key_r;
          cnt_wdata = new_cnt;
          rep_we    = rep_upd;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rep_we) begin
      rep_mem[key_r] <= new_rep;
    end
    rep_q <= rep_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      word_len_r  <= WLEN_REG_BITS'(MAX_WORD_CHARS);
      char_bits_r <= CBITS_REG_BITS'(MAX_CHAR_BITS);
      idx_r       <= '0;
      scan_pos_r  <= '0;
      clr_emit_r  <= 1'b0;
      chk_v_r     <= 1'b0;
      out_strobe  <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_WORD_LEN:  word_len_r  <= pwdata[WLEN_REG_BITS-1:0];
          REG_CHAR_BITS: char_bits_r <= pwdata[CBITS_REG_BITS-1:0];
          default: begin
          end
        endcase
      end
      unique case (state_r)
        S_CLR: begin
          if (idx_r == LAST_IDX) begin
            state_r <= S_IDLE;
            if (clr_emit_r) begin
              out_strobe <= 1'b1;
              out_data   <= pack_code(ST_CLEARED, 1'b0);
            end
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (in_data.operation)
              OP_INSERT: begin
                key_r   <= key;
                a_r     <= a_m;
                b_r     <= b_m;
                beta_r  <= in_data.beta;
                inc_r   <= in_data.increment;
                eq_r    <= equal;
                state_r <= S_UPD;
              end
              OP_READ: begin
                idx_r   <= scan_pos_r;
                chk_v_r <= 1'b0;
                state_r <= S_SCAN1;
              end
              OP_CLEAR: begin
                idx_r      <= '0;
                scan_pos_r <= '0;
                clr_emit_r <= 1'b1;
                state_r    <= S_CLR;
              end
              OP_RESERVED: begin
              end
              default: begin
              end
            endcase
          end
        end
        S_UPD: begin
          out_strobe <= 1'b1;
          state_r    <= S_IDLE;
          if (eq_r) begin
            out_data <= pack_code(ST_SKIPPED, 1'b0);
          end else begin
            out_data <= pack_entry(ST_INSERTED, key_r, rep_upd ? new_rep : rep_q,
                                   new_cnt, 1'b0);
          end
        end
        S_SCAN1, S_SCAN2: begin
          if (issuing) begin
            idx_r <= idx_r + 1'b1;
          end
          chk_v_r   <= issuing;
          chk_idx_r <= idx_r[ADDR_BITS-1:0];
          if (state_r == S_SCAN1) begin
            if (hit) begin
              fnd_idx_r <= chk_idx_r;
              fnd_cnt_r <= cnt_q;
              fnd_rep_r <= rep_q;
              state_r   <= S_SCAN2;
            end else if (at_end) begin
              scan_pos_r <= '0;
              out_strobe <= 1'b1;
              out_data   <= pack_code(ST_NO_MORE, 1'b1);
              state_r    <= S_IDLE;
            end
          end else if (hit || at_end) begin
            scan_pos_r <= {1'b0, fnd_idx_r} + 1'b1;
            out_strobe <= 1'b1;
            out_data   <= pack_entry(ST_ENTRY, fnd_idx_r, fnd_rep_r, fnd_cnt_r, !hit);
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/wch_checker.sv =====
// ----------------------------------------------------------------------------
// wch_checker
// Port level checks of the word correlation histogram, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module wch_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input wch_pkg::in_t  in_data,
  input wch_pkg::out_t out_data,
  input logic          out_strobe
);
  import wch_pkg::*;

  // a result never lasts more than one cycle
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  // every recognized operation occupies the block after its transfer
  a_busy_after_op: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.operation != OP_RESERVED) |=> busy)
    else $error("block not busy after an accepted operation");

  // insert result strobes after the update state, with status inserted or skipped
  a_insert_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.operation == OP_INSERT) |=> ##1
      (out_strobe && (out_data.status == ST_INSERTED || out_data.status == ST_SKIPPED)))
    else $error("insert result missing or wrong status");

  // results only come from work in progress
  a_strobe_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without preceding work");

endmodule

bind word_correlation_histogram wch_checker u_wch_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_data    (in_data),
  .out_data   (out_data),
  .out_strobe (out_strobe)
);

`default_nettype wire
